### hw/rtl/bzs_pkg.sv
// Shared constants, types and a helper function for the cubic Bezier point sampler.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package bzs_pkg;

   localparam int COORD_W     = 16;
   localparam int NUM_AXES    = 3;
   localparam int NUM_CTRL    = 4;
   localparam int IDX_W       = 12;
   localparam int CNT_W       = 13;
   localparam int MAX_SAMPLES = 4096;
   localparam int FRAC_W      = 16;
   localparam int REG_W       = NUM_AXES * COORD_W;
   localparam int WEIGHT_W    = 3 * FRAC_W;
   localparam int PROD_W      = COORD_W + WEIGHT_W;

   localparam int CSR_IDX_W   = 3;
   localparam logic [CSR_IDX_W-1:0] REG_START  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_END    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT  = 3'd4;
   localparam logic [CNT_W-1:0]     COUNT_RESET = 13'd2;

   localparam int SEL_W = 2;
   localparam logic [SEL_W-1:0] SEL_CURVE = 2'd0;
   localparam logic [SEL_W-1:0] SEL_START = 2'd1;
   localparam logic [SEL_W-1:0] SEL_END   = 2'd2;
   localparam logic [SEL_W-1:0] SEL_OOR   = 2'd3;

   // divider: DIV_STEPS quotient bits per stage
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = FRAC_W / DIV_STEPS;

   // stage map: input, divider, two weight stages, multiply, pair sum, final
   localparam int ST_DIV0   = 1;
   localparam int ST_WGT0   = ST_DIV0 + DIV_STAGES;
   localparam int WGT_ST    = 2;
   localparam int ST_MUL    = ST_WGT0 + WGT_ST;
   localparam int LANE_ST   = 3;
   localparam int N_STAGES  = ST_MUL + LANE_ST;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (WEIGHT_W - 1);

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [SEL_W-1:0] sel;
   } side_type;

   typedef struct packed {
      logic [IDX_W-1:0]  rem;
      logic [FRAC_W-1:0] quo;
   } div_type;

   typedef logic [NUM_CTRL-1:0][WEIGHT_W-1:0] weights_type;
   typedef logic [NUM_CTRL-1:0][COORD_W-1:0]  coords_type;

   // restoring division, DIV_STEPS quotient bits
   function automatic div_type div_stage(input div_type x, input logic [IDX_W-1:0] d);
      div_type     r;
      logic [IDX_W:0] r2;
      logic        qb;
      r = x;
      for (int s = 0; s < DIV_STEPS; s++) begin
         r2 = {r.rem, 1'b0};
         qb = (r2 >= {1'b0, d});
         if (qb) begin
            r2 = r2 - {1'b0, d};
         end
         r.rem = r2[IDX_W-1:0];
         r.quo = {r.quo[FRAC_W-2:0], qb};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/bzs_div.sv
// Pipelined restoring divider producing t = floor(index * 2^16 / divisor).
// Depends on bzs_pkg.
`default_nettype none

module bzs_div (
   input  wire logic                                 clock,
   input  wire logic [bzs_pkg::DIV_STAGES-1:0]       en,
   input  wire logic [bzs_pkg::IDX_W-1:0]            idx,
   input  wire logic [bzs_pkg::IDX_W-1:0]            divisor,
   output logic      [bzs_pkg::FRAC_W-1:0]           t
);

   bzs_pkg::div_type div_ff [bzs_pkg::DIV_STAGES];
   bzs_pkg::div_type div_in [bzs_pkg::DIV_STAGES];
   bzs_pkg::div_type seed;

   assign seed = '{rem: idx, quo: '0};

   for (genvar s = 0; s < bzs_pkg::DIV_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign div_in[s] = bzs_pkg::div_stage(seed, divisor);
      end else begin : g_next
         assign div_in[s] = bzs_pkg::div_stage(div_ff[s-1], divisor);
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   assign t = div_ff[bzs_pkg::DIV_STAGES-1].quo;

endmodule

`default_nettype wire

### hw/rtl/bzs_weight.sv
// Two-stage Bernstein weight generator: u^3, 3tu^2, 3t^2u, t^3 from t in Q0.16.
// Depends on bzs_pkg.
`default_nettype none

module bzs_weight (
   input  wire logic                              clock,
   input  wire logic [bzs_pkg::WGT_ST-1:0]        en,
   input  wire logic [bzs_pkg::FRAC_W-1:0]        t,
   output bzs_pkg::weights_type                   weights
);

   localparam logic [bzs_pkg::FRAC_W:0] ONE_Q = (bzs_pkg::FRAC_W+1)'(1) << bzs_pkg::FRAC_W;

   logic [bzs_pkg::FRAC_W-1:0]   t_ff, u_ff, u_in;
   logic [2*bzs_pkg::FRAC_W-1:0] t2_ff, u2_ff;
   logic [bzs_pkg::WEIGHT_W-1:0] u2t, t2u;
   bzs_pkg::weights_type         weights_ff, weights_in;

   assign u_in = bzs_pkg::FRAC_W'(ONE_Q - {1'b0, t});

   always_ff @(posedge clock) begin
      if (en[0]) begin
         t_ff  <= t;
         u_ff  <= u_in;
         t2_ff <= t * t;
         u2_ff <= u_in * u_in;
      end
   end

   always_comb begin
      u2t = bzs_pkg::WEIGHT_W'(u2_ff) * bzs_pkg::WEIGHT_W'(t_ff);
      t2u = bzs_pkg::WEIGHT_W'(t2_ff) * bzs_pkg::WEIGHT_W'(u_ff);
      weights_in[0] = bzs_pkg::WEIGHT_W'(u2_ff) * bzs_pkg::WEIGHT_W'(u_ff);
      weights_in[1] = (u2t << 1) + u2t;
      weights_in[2] = (t2u << 1) + t2u;
      weights_in[3] = bzs_pkg::WEIGHT_W'(t2_ff) * bzs_pkg::WEIGHT_W'(t_ff);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         weights_ff <= weights_in;
      end
   end

   assign weights = weights_ff;

endmodule

`default_nettype wire

### hw/rtl/bzs_lane.sv
// One coordinate lane: weight products, pair sums, rounding and end-case select.
// Depends on bzs_pkg.
`default_nettype none

module bzs_lane (
   input  wire logic                              clock,
   input  wire logic [bzs_pkg::LANE_ST-1:0]       en,
   input  wire bzs_pkg::weights_type              weights,
   input  wire bzs_pkg::coords_type               pts,
   input  wire logic [bzs_pkg::SEL_W-1:0]         sel,
   output logic      [bzs_pkg::COORD_W-1:0]       coord
);

   logic signed [bzs_pkg::PROD_W-1:0] prod_ff [bzs_pkg::NUM_CTRL];
   logic signed [bzs_pkg::PROD_W-1:0] prod_in [bzs_pkg::NUM_CTRL];
   logic signed [bzs_pkg::PROD_W-1:0] pa_ff, pb_ff, sum_w;
   logic        [bzs_pkg::COORD_W-1:0] coord_ff, coord_in;

   always_comb begin
      for (int j = 0; j < bzs_pkg::NUM_CTRL; j++) begin
         prod_in[j] = bzs_pkg::PROD_W'($signed({1'b0, weights[j]}))
                    * bzs_pkg::PROD_W'($signed(pts[j]));
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int j = 0; j < bzs_pkg::NUM_CTRL; j++) begin
            prod_ff[j] <= prod_in[j];
         end
      end
      if (en[1]) begin
         pa_ff <= prod_ff[0] + prod_ff[1];
         pb_ff <= prod_ff[2] + prod_ff[3];
      end
      if (en[2]) begin
         coord_ff <= coord_in;
      end
   end

   // sum is bounded by |coord| * 2^48, so the top bits need no saturation
   assign sum_w = pa_ff + pb_ff + bzs_pkg::ROUND_HALF;

   always_comb begin
      case (sel)
         bzs_pkg::SEL_CURVE: coord_in = sum_w[bzs_pkg::PROD_W-1 -: bzs_pkg::COORD_W];
         bzs_pkg::SEL_START: coord_in = pts[0];
         bzs_pkg::SEL_END:   coord_in = pts[bzs_pkg::NUM_CTRL-1];
         default:            coord_in = '0;
      endcase
   end

   assign coord = coord_ff;

endmodule

`default_nettype wire

### hw/rtl/cubic_bezier_point_sampler.sv
// Cubic Bezier point sampler top level: registers, stage control, lanes.
// Depends on bzs_pkg, bzs_div, bzs_weight, bzs_lane.
//
// Usage:
//   csr_*  : write port for P0, P1, P2, P3 (index 0..3, packed x/y/z) and the
//            sample count (index 4). Always ready. Write only while idle.
//   req_*  : one sample index per item, valid/ready.
//   rsp_*  : index echo, x, y, z and out_of_range flag, valid/ready.
// Pipeline: 10 stages (one input stage, four divider stages of four quotient
//   bits each, two weight stages, multiply, pair sum, round/select).
// Throughput: one item per cycle while not stalled; every stage holds one item.
// Stall: a stage holds while it is full and the next one cannot take its
//   item, so empty stages still fill while rsp_ready is low; req_ready drops
//   only when all ten stages are full and the output is stalled.
// Reset: clears all stage valid bits, points to zero and the count to 2.
`default_nettype none

module cubic_bezier_point_sampler (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bzs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bzs_pkg::REG_W-1:0]         csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [bzs_pkg::IDX_W-1:0]         req_sample_index,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [bzs_pkg::IDX_W-1:0]         rsp_index_echo,
   output logic signed [bzs_pkg::COORD_W-1:0]     rsp_point_x,
   output logic signed [bzs_pkg::COORD_W-1:0]     rsp_point_y,
   output logic signed [bzs_pkg::COORD_W-1:0]     rsp_point_z,
   output logic                                   rsp_out_of_range
);

   localparam int N = bzs_pkg::N_STAGES;

   logic [bzs_pkg::REG_W-1:0] start_ff, first_ff, second_ff, end_ff;
   logic [bzs_pkg::CNT_W-1:0] count_ff, cnt_eff, idx_ext;
   logic [bzs_pkg::IDX_W-1:0] divisor;
   logic [bzs_pkg::SEL_W-1:0] sel_in;
   logic [bzs_pkg::FRAC_W-1:0] t_q;
   bzs_pkg::weights_type      weights;

   logic [N-1:0]              valid_ff;
   logic [N-1:0]              stage_rdy;
   bzs_pkg::side_type         side_ff [N];
   logic [bzs_pkg::COORD_W-1:0] coord [bzs_pkg::NUM_AXES];

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         end_ff    <= '0;
         count_ff  <= bzs_pkg::COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bzs_pkg::REG_START:  start_ff  <= csr_data;
            bzs_pkg::REG_FIRST:  first_ff  <= csr_data;
            bzs_pkg::REG_SECOND: second_ff <= csr_data;
            bzs_pkg::REG_END:    end_ff    <= csr_data;
            bzs_pkg::REG_COUNT:  count_ff  <= csr_data[bzs_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // item classification
   assign cnt_eff = (count_ff > bzs_pkg::CNT_W'(bzs_pkg::MAX_SAMPLES))
                  ? bzs_pkg::CNT_W'(bzs_pkg::MAX_SAMPLES) : count_ff;
   assign divisor = bzs_pkg::IDX_W'(cnt_eff - bzs_pkg::CNT_W'(1));
   assign idx_ext = {1'b0, req_sample_index};

   always_comb begin
      if (idx_ext >= cnt_eff) begin
         sel_in = bzs_pkg::SEL_OOR;
      end else if (req_sample_index == '0) begin
         sel_in = bzs_pkg::SEL_START;
      end else if (idx_ext == cnt_eff - bzs_pkg::CNT_W'(1)) begin
         sel_in = bzs_pkg::SEL_END;
      end else begin
         sel_in = bzs_pkg::SEL_CURVE;
      end
   end

   // stage control
   assign stage_rdy[N-1] = !valid_ff[N-1] || rsp_ready;
   for (genvar k = 0; k < N - 1; k++) begin : g_rdy
      assign stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_rdy[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < N; k++) begin
            if (stage_rdy[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         side_ff[0] <= '{idx: req_sample_index, sel: sel_in};
      end
      for (int k = 1; k < N; k++) begin
         if (stage_rdy[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign req_ready = stage_rdy[0];

   // datapath
   bzs_div u_div (
      .clock   (clock),
      .en      (stage_rdy[bzs_pkg::ST_DIV0 +: bzs_pkg::DIV_STAGES]),
      .idx     (side_ff[0].idx),
      .divisor (divisor),
      .t       (t_q)
   );

   bzs_weight u_weight (
      .clock   (clock),
      .en      (stage_rdy[bzs_pkg::ST_WGT0 +: bzs_pkg::WGT_ST]),
      .t       (t_q),
      .weights (weights)
   );

   for (genvar a = 0; a < bzs_pkg::NUM_AXES; a++) begin : g_lane
      bzs_pkg::coords_type pts;

      assign pts = {end_ff[a*bzs_pkg::COORD_W +: bzs_pkg::COORD_W],
                    second_ff[a*bzs_pkg::COORD_W +: bzs_pkg::COORD_W],
                    first_ff[a*bzs_pkg::COORD_W +: bzs_pkg::COORD_W],
                    start_ff[a*bzs_pkg::COORD_W +: bzs_pkg::COORD_W]};

      bzs_lane u_lane (
         .clock   (clock),
         .en      (stage_rdy[bzs_pkg::ST_MUL +: bzs_pkg::LANE_ST]),
         .weights (weights),
         .pts     (pts),
         .sel     (side_ff[N-2].sel),
         .coord   (coord[a])
      );
   end

   assign rsp_valid        = valid_ff[N-1];
   assign rsp_index_echo   = side_ff[N-1].idx;
   assign rsp_out_of_range = (side_ff[N-1].sel == bzs_pkg::SEL_OOR);
   assign rsp_point_x      = coord[0];
   assign rsp_point_y      = coord[1];
   assign rsp_point_z      = coord[2];

`ifndef NO_ASSERTIONS
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |->
         rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0)
      else $error("out-of-range item with nonzero coordinates");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff) && !rsp_ready)
      else $error("input stalled while the pipeline has a free stage");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_start_exact: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range && rsp_index_echo == '0 |->
         rsp_point_x == start_ff[bzs_pkg::COORD_W-1:0])
      else $error("index zero does not return the start point");
`endif

endmodule

`default_nettype wire
